// ----- src/erfr_pkg.sv -----
`timescale 1ns / 1ps
package erfr_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int CORDIC_MAX = 24;
  localparam int ITERS = (ANGLE_BITS > CORDIC_MAX) ? CORDIC_MAX : ANGLE_BITS;
  localparam int CW = 34;
  localparam int ZW = 34;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [31:0] DEG16_Q20 = 32'sd961263669;
  localparam int SW = 58;

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [ZW-1:0] zval_t;
  typedef logic signed [15:0] rate_t;

  typedef struct packed {
    rate_t bx;
    rate_t by;
    rate_t bz;
  } rates_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    zval_t z;
    logic  flip;
  } cordic_t;

  typedef struct packed {
    cval_t s;
    cval_t c;
  } trig_t;

  function automatic zval_t atan_entry(input int i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'd536870912;
      1: t = 32'd316933406;
      2: t = 32'd167458907;
      3: t = 32'd85004756;
      4: t = 32'd42667331;
      5: t = 32'd21354465;
      6: t = 32'd10679838;
      7: t = 32'd5340245;
      8: t = 32'd2670163;
      9: t = 32'd1335087;
      10: t = 32'd667544;
      11: t = 32'd333772;
      12: t = 32'd166886;
      13: t = 32'd83443;
      14: t = 32'd41722;
      15: t = 32'd20861;
      16: t = 32'd10430;
      17: t = 32'd5215;
      18: t = 32'd2608;
      19: t = 32'd1304;
      20: t = 32'd652;
      21: t = 32'd326;
      22: t = 32'd163;
      23: t = 32'd81;
      default: t = 32'd0;
    endcase
    return zval_t'({2'b00, t});
  endfunction

  function automatic cval_t m30(input cval_t a, input cval_t b);
    logic signed [2*CW-1:0] p;
    p = a * b + (68'sd1 <<< 29);
    return cval_t'(p >>> 30);
  endfunction

endpackage

// ----- src/erfr_cordic.sv -----
`timescale 1ns / 1ps
module erfr_cordic (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [15:0]     angle_i,
  output erfr_pkg::trig_t trig_o
);

  erfr_pkg::cordic_t st_q [erfr_pkg::ITERS+1];
  erfr_pkg::cordic_t st_d [erfr_pkg::ITERS+1];

  logic [31:0] a_w;
  logic [31:0] a_f;
  logic        flip_w;

  always_comb begin
    a_w = {angle_i, 16'd0} & ~((32'd1 << (32 - erfr_pkg::ANGLE_BITS)) - 32'd1);
    flip_w = a_w[31] ^ a_w[30];
    a_f = flip_w ? a_w + 32'h8000_0000 : a_w;
    st_d[0].x = erfr_pkg::GAIN_Q30;
    st_d[0].y = '0;
    st_d[0].z = erfr_pkg::zval_t'($signed(a_f));
    st_d[0].flip = flip_w;
  end

  for (genvar i = 0; i < erfr_pkg::ITERS; i++) begin : g_it
    always_comb begin
      st_d[i+1].flip = st_q[i].flip;
      if (!st_q[i].z[erfr_pkg::ZW-1]) begin
        st_d[i+1].x = st_q[i].x - (st_q[i].y >>> i);
        st_d[i+1].y = st_q[i].y + (st_q[i].x >>> i);
        st_d[i+1].z = st_q[i].z - erfr_pkg::atan_entry(i);
      end else begin
        st_d[i+1].x = st_q[i].x + (st_q[i].y >>> i);
        st_d[i+1].y = st_q[i].y - (st_q[i].x >>> i);
        st_d[i+1].z = st_q[i].z + erfr_pkg::atan_entry(i);
      end
    end
  end

  for (genvar i = 0; i <= erfr_pkg::ITERS; i++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en_i) st_q[i] <= st_d[i];
    end
  end

  assign trig_o.c = st_q[erfr_pkg::ITERS].flip ? -st_q[erfr_pkg::ITERS].x
                                                : st_q[erfr_pkg::ITERS].x;
  assign trig_o.s = st_q[erfr_pkg::ITERS].flip ? -st_q[erfr_pkg::ITERS].y
                                                : st_q[erfr_pkg::ITERS].y;

endmodule

// ----- src/erfr_matrix.sv -----
`timescale 1ns / 1ps
module erfr_matrix (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  erfr_pkg::trig_t       yaw_i,
  input  erfr_pkg::trig_t       tha_i,
  input  erfr_pkg::trig_t       phi_i,
  output erfr_pkg::cval_t [8:0] mat_o
);

  erfr_pkg::trig_t y1_q, t1_q, f1_q;
  erfr_pkg::cval_t sfst_q, cfst_q;
  erfr_pkg::cval_t p_q [13];
  erfr_pkg::cval_t [8:0] m_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y1_q   <= yaw_i;
      t1_q   <= tha_i;
      f1_q   <= phi_i;
      sfst_q <= erfr_pkg::m30(phi_i.s, tha_i.s);
      cfst_q <= erfr_pkg::m30(phi_i.c, tha_i.s);
      p_q[0]  <= erfr_pkg::m30(t1_q.c, y1_q.c);
      p_q[1]  <= erfr_pkg::m30(t1_q.c, y1_q.s);
      p_q[2]  <= -t1_q.s;
      p_q[3]  <= erfr_pkg::m30(sfst_q, y1_q.c);
      p_q[4]  <= erfr_pkg::m30(f1_q.c, y1_q.s);
      p_q[5]  <= erfr_pkg::m30(sfst_q, y1_q.s);
      p_q[6]  <= erfr_pkg::m30(f1_q.c, y1_q.c);
      p_q[7]  <= erfr_pkg::m30(f1_q.s, t1_q.c);
      p_q[8]  <= erfr_pkg::m30(cfst_q, y1_q.c);
      p_q[9]  <= erfr_pkg::m30(f1_q.s, y1_q.s);
      p_q[10] <= erfr_pkg::m30(cfst_q, y1_q.s);
      p_q[11] <= erfr_pkg::m30(f1_q.s, y1_q.c);
      p_q[12] <= erfr_pkg::m30(f1_q.c, t1_q.c);
      m_q[0] <= p_q[0];
      m_q[1] <= p_q[1];
      m_q[2] <= p_q[2];
      m_q[3] <= p_q[3] - p_q[4];
      m_q[4] <= p_q[5] + p_q[6];
      m_q[5] <= p_q[7];
      m_q[6] <= p_q[8] + p_q[9];
      m_q[7] <= p_q[10] - p_q[11];
      m_q[8] <= p_q[12];
    end
  end

  assign mat_o = m_q;

endmodule

// ----- src/erfr_dot.sv -----
`timescale 1ns / 1ps
module erfr_dot (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  erfr_pkg::rate_t      r0_i,
  input  erfr_pkg::rate_t      r1_i,
  input  erfr_pkg::rate_t      r2_i,
  input  erfr_pkg::cval_t      m0_i,
  input  erfr_pkg::cval_t      m1_i,
  input  erfr_pkg::cval_t      m2_i,
  output erfr_pkg::rate_t      res_o
);

  logic signed [erfr_pkg::SW-1:0] p0_q, p1_q, p2_q, sum_q;
  logic signed [erfr_pkg::SW-1:0] sum_rnd;
  logic signed [31:0] q24;
  logic signed [erfr_pkg::SW+16:0] sc_q;
  logic signed [erfr_pkg::SW+16:0] sc_rnd;
  logic signed [erfr_pkg::SW-8:0] v;
  erfr_pkg::rate_t res_q;

  assign sum_rnd = sum_q + (58'sd1 <<< 16);
  assign q24 = sum_rnd[48:17];
  assign sc_rnd = sc_q + (75'sd1 <<< 23);
  assign v = sc_rnd[erfr_pkg::SW+16:24];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q  <= erfr_pkg::SW'(r0_i * m0_i);
      p1_q  <= erfr_pkg::SW'(r1_i * m1_i);
      p2_q  <= erfr_pkg::SW'(r2_i * m2_i);
      sum_q <= p0_q + p1_q + p2_q;
      sc_q  <= q24 * erfr_pkg::DEG16_Q20;
      if (v > 51'sd32767) res_q <= 16'sh7fff;
      else if (v < -51'sd32768) res_q <= 16'sh8000;
      else res_q <= v[15:0];
    end
  end

  assign res_o = res_q;

endmodule

// ----- src/euler_rate_frame_rotation.sv -----
`timescale 1ns / 1ps
// throughput: one word per cycle; a stall freezes the whole pipeline
// output register holds the finished word while the pipe is frozen until ready
// reset: asynchronous active low, clears the valid bits only
module euler_rate_frame_rotation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] body_rate_x_i,
  input  logic [15:0] body_rate_y_i,
  input  logic [15:0] body_rate_z_i,
  input  logic [15:0] angle_yaw_i,
  input  logic [15:0] angle_tilt_a_i,
  input  logic [15:0] angle_tilt_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] frame_rate_x_o,
  output logic [15:0] frame_rate_y_o,
  output logic [15:0] frame_rate_z_o
);

  localparam int LAT = erfr_pkg::ITERS + 8;

  logic [LAT-1:0] vld_q;
  logic en;
  erfr_pkg::trig_t ty, ta, tb;
  erfr_pkg::cval_t [8:0] mat;
  erfr_pkg::rates_t rd_q [erfr_pkg::ITERS+4];

  assign en = out_ready_i || !vld_q[LAT-1];
  assign in_ready_o = en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q[0] <= {body_rate_x_i, body_rate_y_i, body_rate_z_i};
      for (int k = 1; k < erfr_pkg::ITERS + 4; k++) rd_q[k] <= rd_q[k-1];
    end
  end

  erfr_cordic u_yaw (.clk_i, .en_i(en), .angle_i(angle_yaw_i),    .trig_o(ty));
  erfr_cordic u_tha (.clk_i, .en_i(en), .angle_i(angle_tilt_a_i), .trig_o(ta));
  erfr_cordic u_phi (.clk_i, .en_i(en), .angle_i(angle_tilt_b_i), .trig_o(tb));

  erfr_matrix u_mat (.clk_i, .en_i(en), .yaw_i(ty), .tha_i(ta), .phi_i(tb), .mat_o(mat));

  erfr_pkg::rates_t r;
  assign r = rd_q[erfr_pkg::ITERS+3];

  erfr_dot u_d0 (.clk_i, .en_i(en), .r0_i(r.bx), .r1_i(r.by), .r2_i(r.bz),
    .m0_i(mat[0]), .m1_i(mat[3]), .m2_i(mat[6]), .res_o(frame_rate_x_o));
  erfr_dot u_d1 (.clk_i, .en_i(en), .r0_i(r.bx), .r1_i(r.by), .r2_i(r.bz),
    .m0_i(mat[1]), .m1_i(mat[4]), .m2_i(mat[7]), .res_o(frame_rate_y_o));
  erfr_dot u_d2 (.clk_i, .en_i(en), .r0_i(r.bx), .r1_i(r.by), .r2_i(r.bz),
    .m0_i(mat[2]), .m1_i(mat[5]), .m2_i(mat[8]), .res_o(frame_rate_z_o));

endmodule

// ----- src/erfr_checker.sv -----
`timescale 1ns / 1ps
module erfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] frame_rate_x_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_rate_x_o))
    else $error("word dropped under stall");

  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled with free output");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while pipe frozen");

endmodule

bind euler_rate_frame_rotation erfr_checker u_chk (.*);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  localparam int LATENCY = erfr_pkg::ITERS + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM = 600;
  localparam int N_DIRECTED = 18;

  typedef struct {
    logic [15:0] bx, by, bz, yaw, ta, tb;
  } rot_in_t;

  typedef struct {
    logic [15:0] x, y, z;
  } rot_out_t;

  typedef struct {
    rot_in_t   in;
    logic      known;
    rot_out_t  res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] body_rate_x_i = '0;
  logic [15:0] body_rate_y_i = '0;
  logic [15:0] body_rate_z_i = '0;
  logic [15:0] angle_yaw_i = '0;
  logic [15:0] angle_tilt_a_i = '0;
  logic [15:0] angle_tilt_b_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] frame_rate_x_o;
  logic [15:0] frame_rate_y_o;
  logic [15:0] frame_rate_z_o;

  euler_rate_frame_rotation dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rot_out_t   pending_rates[$];
  int         errors = 0;
  int         table_errors = 0;
  int         cycles = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_off = 1'b0;
  bit         hold_done = 1'b0;
  int         hold_len = 0;
  logic [31:0] atan_q30[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return round_shr(a * b, 30);
  endfunction

  function automatic void angle_trig(input logic [15:0] ang, output longint s,
                                     output longint c);
    logic [31:0] a;
    logic [31:0] keep;
    bit          flip;
    longint      x, y, z, nx;
    a = {ang, 16'h0};
    keep = (32'd1 << (32 - erfr_pkg::ANGLE_BITS)) - 1;
    a &= ~keep;
    flip = 1'b0;
    if (((a + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      a += 32'h8000_0000;
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = longint'(signed'(a));
    for (int i = 0; i < erfr_pkg::ITERS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        z -= longint'(atan_q30[i]);
      end else begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        z += longint'(atan_q30[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [15:0] to_deg16(longint acc);
    longint v;
    v = round_shr(round_shr(acc, 17) * 64'sd961263669, 24);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic rot_out_t rotate_rates(rot_in_t w);
    longint sy, cy, st, ct, sf, cf, sfst, cfst, bx, by, bz;
    longint m[3][3];
    rot_out_t r;
    angle_trig(w.yaw, sy, cy);
    angle_trig(w.ta, st, ct);
    angle_trig(w.tb, sf, cf);
    bx = longint'(signed'(w.bx));
    by = longint'(signed'(w.by));
    bz = longint'(signed'(w.bz));
    sfst = mul_q30(sf, st);
    cfst = mul_q30(cf, st);
    m[0][0] = mul_q30(ct, cy);
    m[0][1] = mul_q30(ct, sy);
    m[0][2] = -st;
    m[1][0] = mul_q30(sfst, cy) - mul_q30(cf, sy);
    m[1][1] = mul_q30(sfst, sy) + mul_q30(cf, cy);
    m[1][2] = mul_q30(sf, ct);
    m[2][0] = mul_q30(cfst, cy) + mul_q30(sf, sy);
    m[2][1] = mul_q30(cfst, sy) - mul_q30(sf, cy);
    m[2][2] = mul_q30(cf, ct);
    r.x = to_deg16(bx * m[0][0] + by * m[1][0] + bz * m[2][0]);
    r.y = to_deg16(bx * m[0][1] + by * m[1][1] + bz * m[2][1]);
    r.z = to_deg16(bx * m[0][2] + by * m[1][2] + bz * m[2][2]);
    return r;
  endfunction

  // first row: zero rates give zero
  dir_row_t directed[N_DIRECTED] = '{
    '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000}},
    '{'{16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{0, 0, 0}},
    '{'{16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{0, 0, 0}},
    '{'{16'h0800, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{0, 0, 0}},
    '{'{16'h0000, 16'h0800, 16'h0000, 16'h4000, 16'h0000, 16'h0000}, 1'b0, '{0, 0, 0}},
    '{'{16'h0000, 16'h0000, 16'h0800, 16'h0000, 16'h4000, 16'h0000}, 1'b0, '{0, 0, 0}},
    '{'{16'h0800, 16'h0800, 16'h0800, 16'h0000, 16'h0000, 16'h4000}, 1'b0, '{0, 0, 0}},
    '{'{16'h0800, 16'hf800, 16'h0400, 16'hc000, 16'hc000, 16'hc000}, 1'b0, '{0, 0, 0}},
    '{'{16'h0800, 16'h0400, 16'h0200, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '{0, 0, 0}},
    '{'{16'h0800, 16'h0400, 16'h0200, 16'h7fff, 16'h7fff, 16'h7fff}, 1'b0, '{0, 0, 0}},
    '{'{16'h0800, 16'h0400, 16'h0200, 16'h3fff, 16'hbfff, 16'h4001}, 1'b0, '{0, 0, 0}},
    '{'{16'hffff, 16'h0001, 16'hffff, 16'hffff, 16'h0001, 16'hffff}, 1'b0, '{0, 0, 0}},
    '{'{16'h7fff, 16'h8000, 16'h7fff, 16'h2000, 16'he000, 16'h6000}, 1'b0, '{0, 0, 0}},
    '{'{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa}, 1'b0, '{0, 0, 0}},
    '{'{16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555}, 1'b0, '{0, 0, 0}},
    '{'{16'h0100, 16'h0200, 16'h0300, 16'h0001, 16'hfffe, 16'h8001}, 1'b0, '{0, 0, 0}},
    '{'{16'h7fff, 16'h7fff, 16'h0000, 16'h2000, 16'h0000, 16'h0000}, 1'b0, '{0, 0, 0}},
    '{'{16'h8000, 16'h0000, 16'h8000, 16'h0000, 16'h2000, 16'h2000}, 1'b0, '{0, 0, 0}}
  };

  task automatic send_word(input rot_in_t w);
    while (($urandom_range(99) < send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    body_rate_x_i <= w.bx;
    body_rate_y_i <= w.by;
    body_rate_z_i <= w.bz;
    angle_yaw_i <= w.yaw;
    angle_tilt_a_i <= w.ta;
    angle_tilt_b_i <= w.tb;
    do @(posedge clk_i); while (!in_ready_o);
    pending_rates.push_back(rotate_rates(w));
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(8)) - 16'd4;
      3: return {$urandom_range(3) == 0 ? 2'b11 : 2'b00, 14'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("euler_rate_frame_rotation verification failed");
      $finish;
    end
  end

  // receiver side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_len > 0) begin
        hold_len <= hold_len - 1;
        out_ready_i <= 1'b0;
      end else if (hold_off && !hold_done) begin
        hold_done <= 1'b1;
        hold_len <= 200;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_rates.size() == 0) begin
          $display("%0t: unexpected word x=%h y=%h z=%h", $time,
                   frame_rate_x_o, frame_rate_y_o, frame_rate_z_o);
          errors++;
        end else begin
          rot_out_t e;
          e = pending_rates.pop_front();
          if (frame_rate_x_o !== e.x) begin
            $display("%0t: frame_rate_x expected %h actual %h", $time, e.x, frame_rate_x_o);
            errors++;
          end
          if (frame_rate_y_o !== e.y) begin
            $display("%0t: frame_rate_y expected %h actual %h", $time, e.y, frame_rate_y_o);
            errors++;
          end
          if (frame_rate_z_o !== e.z) begin
            $display("%0t: frame_rate_z expected %h actual %h", $time, e.z, frame_rate_z_o);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    rot_in_t  w;
    rot_out_t p;
    int       drain;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed[i].known) begin
        p = rotate_rates(directed[i].in);
        if (p.x !== directed[i].res.x || p.y !== directed[i].res.y ||
            p.z !== directed[i].res.z) begin
          $display("%0t: table row %0d expected %h %h %h actual %h %h %h", $time, i,
                   directed[i].res.x, directed[i].res.y, directed[i].res.z,
                   p.x, p.y, p.z);
          table_errors++;
        end
      end
      send_word(directed[i].in);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      case (i / 100)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        3: begin send_idle_pct = 22; recv_stall_pct = 22; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (i == 450) hold_off <= 1'b1;
      w.bx = rand_field();
      w.by = rand_field();
      w.bz = rand_field();
      w.yaw = rand_field();
      w.ta = rand_field();
      w.tb = rand_field();
      send_word(w);
    end
    in_valid_i <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk_i);
    drain = 0;
    while (drain < 4 * LATENCY) begin
      @(posedge clk_i);
      drain++;
    end
    if (errors == 0 && table_errors == 0) begin
      $display("euler_rate_frame_rotation verification clean");
    end else begin
      $display("euler_rate_frame_rotation verification failed");
    end
    $finish;
  end

endmodule
